FILE: hw/rtl/rtvd_pkg.sv
// rtvd_pkg: shared types and constants for the rolling trade volume delta block
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rtvd_pkg;

  typedef enum logic [1:0] {
    CMD_TRADE = 2'd0,
    CMD_OTHER = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_WINDOW     = 2'd0,
    CFG_FILTER_EN  = 2'd1,
    CFG_FILTER_SYM = 2'd2,
    CFG_NONE       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVICT,
    S_ADD,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  localparam int Q_BITS    = 15;
  localparam int STEP_W    = 4;
  localparam int RATIO_W   = 16;
  localparam int ENTRY_W   = 32;
  localparam int CNT_W     = 32;
  localparam int WIN_W     = 11;
  localparam int SYM_W     = 16;
  localparam int QTY_W     = 32;
  localparam int VOL_W     = 48;
  localparam int TOTAL_W   = 49;
  localparam int CFG_DATA_W = 16;

endpackage

`default_nettype wire

FILE: hw/rtl/rtvd_ring.sv
// rtvd_ring: trade ring memory, one write port and one registered read port
// depends on rtvd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtvd_ring #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire                               clk,
  input  wire                               we,
  input  wire  [ADDR_W-1:0]                 waddr,
  input  wire  [rtvd_pkg::ENTRY_W-1:0]      wdata,
  input  wire  [ADDR_W-1:0]                 raddr,
  output logic [rtvd_pkg::ENTRY_W-1:0]      rdata
);

  logic [rtvd_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rtvd_div.sv
// rtvd_div: restoring divider, one quotient bit per cycle, for the Q2.14 ratio
// depends on rtvd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtvd_div #(
  parameter int TOT_W = 49
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  input  wire  [TOT_W-1:0]                 mag,
  input  wire  [TOT_W-1:0]                 total,
  output logic                             done,
  output logic [rtvd_pkg::Q_BITS-1:0]      quotient
);

  logic                              busy;
  logic [rtvd_pkg::STEP_W-1:0]       cnt;
  logic [TOT_W:0]                    rem;
  logic [TOT_W-1:0]                  tot;
  logic [rtvd_pkg::Q_BITS-1:0]       q;
  logic                              ge;
  logic [TOT_W:0]                    rem_sub;

  assign ge      = rem >= {1'b0, tot};
  assign rem_sub = ge ? rem - {1'b0, tot} : rem;
  assign done    = busy && (cnt == rtvd_pkg::STEP_W'(1));
  assign quotient = (tot == '0) ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= rtvd_pkg::STEP_W'(rtvd_pkg::Q_BITS);
    end else if (busy) begin
      cnt <= cnt - rtvd_pkg::STEP_W'(1);
      if (cnt == rtvd_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, mag};
      tot <= total;
      q   <= '0;
    end else if (busy) begin
      rem <= {rem_sub[TOT_W-1:0], 1'b0};
      q   <= {q[rtvd_pkg::Q_BITS-2:0], ge};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rolling_trade_volume_delta.sv
// rolling_trade_volume_delta: sliding window buy/sell volume sums with delta ratio
// depends on rtvd_pkg, rtvd_ring, rtvd_div
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | command symbol_id buy_aggressor quantity
// out     | output    | out_valid / out_stall  | accepted volumes delta total ratio count
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// an item goes from accept to loaded result through accept, evict, add,
// prepare, the one-bit-per-cycle ratio divider, then load once the output is free
// the ring read for the eviction is issued at accept and used in the next cycle, the evict state
// rst clears sums, count, pointer and config; ring contents need no reset
// a result waiting under out_stall does not block the next accept

module rolling_trade_volume_delta #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int SUM_BITS     = 48
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [1:0]                            command,
  input  wire  [rtvd_pkg::SYM_W-1:0]            symbol_id,
  input  wire                                   buy_aggressor,
  input  wire  signed [rtvd_pkg::QTY_W-1:0]     quantity,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  accepted,
  output logic [rtvd_pkg::VOL_W-1:0]            buy_volume,
  output logic [rtvd_pkg::VOL_W-1:0]            sell_volume,
  output logic signed [rtvd_pkg::TOTAL_W-1:0]   net_delta,
  output logic [rtvd_pkg::TOTAL_W-1:0]          total_volume,
  output logic signed [rtvd_pkg::RATIO_W-1:0]   delta_ratio,
  output logic [rtvd_pkg::CNT_W-1:0]            observation_count,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [1:0]                            cfg_index,
  input  wire  [rtvd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int EXT_W = PTR_W + 1;
  localparam int TOT_W = SUM_BITS + 1;
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(WINDOW_DEPTH);
  localparam logic [rtvd_pkg::CNT_W-1:0] DEPTH_CNT = rtvd_pkg::CNT_W'(WINDOW_DEPTH);
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  rtvd_pkg::state_t state, state_next;

  logic [rtvd_pkg::WIN_W-1:0]  window_size;
  logic                        filter_enable;
  logic [rtvd_pkg::SYM_W-1:0]  filter_symbol;

  logic [PTR_W-1:0]            write_pointer;
  logic [SUM_BITS-1:0]         buy_sum;
  logic [SUM_BITS-1:0]         sell_sum;
  logic [rtvd_pkg::CNT_W-1:0]  held_count;

  logic                        item_clear;
  logic                        item_trade;
  logic                        item_buy;
  logic [30:0]                 item_qty;

  logic                        neg;
  logic [SUM_BITS-1:0]         mag_r;
  logic [TOT_W-1:0]            total_r;

  logic                        in_fire;
  logic                        out_free;
  logic                        ring_we;
  logic                        div_start;
  logic                        out_load;
  logic                        div_done;
  logic [rtvd_pkg::Q_BITS-1:0] div_q;

  logic                        win_mode;
  logic [rtvd_pkg::CNT_W-1:0]  win;
  logic                        evict;
  logic [EXT_W-1:0]            wp_ext;
  logic [EXT_W-1:0]            cnt_ext;
  logic [EXT_W-1:0]            old_ext;
  logic [PTR_W-1:0]            old_addr;
  logic [EXT_W-1:0]            wp_inc;
  logic [rtvd_pkg::ENTRY_W-1:0] ring_rdata;
  logic [rtvd_pkg::ENTRY_W-1:0] entry;
  logic [SUM_BITS-1:0]         old_qty;
  logic [SUM_BITS-1:0]         new_qty;
  logic [SUM_BITS:0]           buy_add;
  logic [SUM_BITS:0]           sell_add;
  logic                        cmd_trade_ok;
  logic [TOT_W-1:0]            total_c;
  logic                        neg_c;
  logic [SUM_BITS-1:0]         mag_c;
  logic [rtvd_pkg::TOTAL_W-1:0] mag49;
  logic [rtvd_pkg::RATIO_W-1:0] q16;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign win_mode = (window_size != '0);
  assign win = (rtvd_pkg::CNT_W'(window_size) > DEPTH_CNT) ? DEPTH_CNT
                                                          : rtvd_pkg::CNT_W'(window_size);
  assign evict   = win_mode && (held_count >= win);
  assign wp_ext  = {1'b0, write_pointer};
  assign cnt_ext = held_count[EXT_W-1:0];
  assign old_ext = (wp_ext >= cnt_ext) ? wp_ext - cnt_ext : wp_ext + DEPTH_EXT - cnt_ext;
  assign old_addr = old_ext[PTR_W-1:0];
  assign wp_inc  = wp_ext + EXT_W'(1);
  assign entry   = {item_buy, item_qty};
  assign old_qty = SUM_BITS'(ring_rdata[30:0]);
  assign new_qty = SUM_BITS'(item_qty);
  assign buy_add  = {1'b0, buy_sum} + {1'b0, new_qty};
  assign sell_add = {1'b0, sell_sum} + {1'b0, new_qty};

  assign total_c = {1'b0, buy_sum} + {1'b0, sell_sum};
  assign neg_c   = sell_sum > buy_sum;
  assign mag_c   = neg_c ? sell_sum - buy_sum : buy_sum - sell_sum;
  assign mag49   = rtvd_pkg::TOTAL_W'(mag_r);
  assign q16     = {1'b0, div_q};

  always_comb begin
    cmd_trade_ok = 1'b0;
    unique case (rtvd_pkg::cmd_t'(command))
      rtvd_pkg::CMD_TRADE: begin
        cmd_trade_ok = (quantity > 0) &&
                       (!filter_enable || (symbol_id == filter_symbol));
      end
      default: begin
        cmd_trade_ok = 1'b0;
      end
    endcase
  end

  rtvd_ring #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_pointer),
    .wdata (entry),
    .raddr (old_addr),
    .rdata (ring_rdata)
  );

  rtvd_div #(
    .TOT_W (TOT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      ({1'b0, mag_c}),
    .total    (total_c),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rtvd_pkg::S_IDLE:  if (in_fire) state_next = rtvd_pkg::S_EVICT;
      rtvd_pkg::S_EVICT: state_next = rtvd_pkg::S_ADD;
      rtvd_pkg::S_ADD:   state_next = rtvd_pkg::S_PREP;
      rtvd_pkg::S_PREP:  state_next = rtvd_pkg::S_DIV;
      rtvd_pkg::S_DIV:   if (div_done) state_next = rtvd_pkg::S_DONE;
      rtvd_pkg::S_DONE:  if (out_free) state_next = rtvd_pkg::S_IDLE;
      default:           state_next = rtvd_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ring_we   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      rtvd_pkg::S_IDLE: in_stall  = 1'b0;
      rtvd_pkg::S_ADD:  ring_we   = item_trade && win_mode;
      rtvd_pkg::S_PREP: div_start = 1'b1;
      rtvd_pkg::S_DONE: out_load  = out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtvd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= '0;
      filter_enable <= 1'b0;
      filter_symbol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (rtvd_pkg::cfg_idx_t'(cfg_index))
        rtvd_pkg::CFG_WINDOW:     window_size   <= cfg_data[rtvd_pkg::WIN_W-1:0];
        rtvd_pkg::CFG_FILTER_EN:  filter_enable <= cfg_data[0];
        rtvd_pkg::CFG_FILTER_SYM: filter_symbol <= cfg_data;
        default: ;
      endcase
    end
  end

  // accepted item fields
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_clear <= (rtvd_pkg::cmd_t'(command) == rtvd_pkg::CMD_CLEAR);
      item_trade <= cmd_trade_ok;
      item_buy   <= buy_aggressor;
      item_qty   <= quantity[30:0];
    end
  end

  // window state, read-modify-write with the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      buy_sum       <= '0;
      sell_sum      <= '0;
      held_count    <= '0;
    end else if (cfg_valid && cfg_ready &&
                 (rtvd_pkg::cfg_idx_t'(cfg_index) == rtvd_pkg::CFG_WINDOW)) begin
      write_pointer <= '0;
      buy_sum       <= '0;
      sell_sum      <= '0;
      held_count    <= '0;
    end else begin
      unique case (state)
        rtvd_pkg::S_EVICT: begin
          if (item_clear) begin
            write_pointer <= '0;
            buy_sum       <= '0;
            sell_sum      <= '0;
            held_count    <= '0;
          end else if (item_trade && evict) begin
            if (ring_rdata[31]) begin
              buy_sum <= (old_qty > buy_sum) ? '0 : buy_sum - old_qty;
            end else begin
              sell_sum <= (old_qty > sell_sum) ? '0 : sell_sum - old_qty;
            end
            held_count <= held_count - rtvd_pkg::CNT_W'(1);
          end
        end
        rtvd_pkg::S_ADD: begin
          if (item_trade) begin
            if (item_buy) begin
              buy_sum <= buy_add[SUM_BITS] ? SUM_MAX : buy_add[SUM_BITS-1:0];
            end else begin
              sell_sum <= sell_add[SUM_BITS] ? SUM_MAX : sell_add[SUM_BITS-1:0];
            end
            if (held_count != '1) begin
              held_count <= held_count + rtvd_pkg::CNT_W'(1);
            end
            if (win_mode) begin
              write_pointer <= (wp_inc >= DEPTH_EXT) ? '0 : wp_inc[PTR_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg     <= neg_c;
      mag_r   <= mag_c;
      total_r <= total_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted          <= item_trade;
      buy_volume        <= rtvd_pkg::VOL_W'(buy_sum);
      sell_volume       <= rtvd_pkg::VOL_W'(sell_sum);
      net_delta         <= neg ? -mag49 : mag49;
      total_volume      <= rtvd_pkg::TOTAL_W'(total_r);
      delta_ratio       <= neg ? -q16 : q16;
      observation_count <= held_count;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(write_pointer) < DEPTH_CNT)
    else $error("write pointer beyond ring depth");

  a_held_window: assert property (@(posedge clk) disable iff (rst)
    win_mode |-> held_count <= win)
    else $error("held count exceeds window");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == rtvd_pkg::S_DIV)
    else $error("divider finished outside divide state");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delta_ratio <= 16384 && delta_ratio >= -16384))
    else $error("delta ratio out of range");

endmodule

`default_nettype wire
